// ----- hdl/rvc_pkg.sv -----
package rvc_pkg;
    localparam int MEM_BYTES = 1024;
    localparam int MA_W = $clog2(MEM_BYTES);

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_WRMEM = 2'd1,
        OP_RDMEM = 2'd2,
        OP_RDREG = 2'd3
    } item_op_t;

    localparam logic [6:0] OPC_R    = 7'b0110011;
    localparam logic [6:0] OPC_I    = 7'b0010011;
    localparam logic [6:0] OPC_JAL  = 7'b1101111;
    localparam logic [6:0] OPC_BR   = 7'b1100011;
    localparam logic [6:0] OPC_LW   = 7'b0000011;
    localparam logic [6:0] OPC_SW   = 7'b0100011;
    localparam logic [6:0] OPC_HALT = 7'b1111111;
    localparam logic [6:0] F7_SUB   = 7'b0100000;

    typedef enum logic [3:0] {
        K_NOP, K_ADD, K_SUB, K_XOR, K_OR, K_AND, K_LW, K_SW, K_JAL, K_BEQ, K_BNE, K_HALT,
        K_WRMEM, K_RDMEM, K_RDREG
    } kind_t;

    // execute unit phases: register read, memory bank read, retire
    typedef enum logic [1:0] {S_A, S_B, S_C} st_t;

    // classified item passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic        use_imm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] data;
        logic [MA_W-1:0] addr;
    } dec_t;
endpackage

// ----- hdl/rvc_front.sv -----
module rvc_front import rvc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_instr,
    input  logic [9:0]  s_mem_address,
    input  logic [31:0] s_mem_data,
    input  logic [4:0]  s_reg_index,
    output logic        q_valid,
    input  logic        q_ready,
    output dec_t        q_item
);
    // two-entry queue
    dec_t       q_mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    dec_t       d;
    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       push, pop;

    assign opc = s_instr[6:0];
    assign f3  = s_instr[14:12];
    assign f7  = s_instr[31:25];

    always_comb begin
        d = '0;
        d.rd   = s_instr[11:7];
        d.rs1  = s_instr[19:15];
        d.rs2  = s_instr[24:20];
        d.data = s_mem_data;
        d.addr = MA_W'(s_mem_address);
        d.imm  = {{20{s_instr[31]}}, s_instr[31:20]};
        d.kind = K_NOP;
        case (item_op_t'(s_opcode))
            OP_WRMEM: d.kind = K_WRMEM;
            OP_RDMEM: d.kind = K_RDMEM;
            OP_RDREG: begin
                d.kind = K_RDREG;
                d.rs1  = s_reg_index;
            end
            default: begin
                if (opc == OPC_HALT) d.kind = K_HALT;
                else if (opc == OPC_R) begin
                    if (f7 == 7'd0 && f3 == 3'd0) d.kind = K_ADD;
                    else if (f7 == F7_SUB && f3 == 3'd0) d.kind = K_SUB;
                    else if (f7 == 7'd0 && f3 == 3'd4) d.kind = K_XOR;
                    else if (f7 == 7'd0 && f3 == 3'd6) d.kind = K_OR;
                    else if (f7 == 7'd0 && f3 == 3'd7) d.kind = K_AND;
                end else if (opc == OPC_I) begin
                    d.use_imm = 1'b1;
                    case (f3)
                        3'd0: d.kind = K_ADD;
                        3'd4: d.kind = K_XOR;
                        3'd6: d.kind = K_OR;
                        3'd7: d.kind = K_AND;
                        default: d.kind = K_NOP;
                    endcase
                end else if (opc == OPC_LW && f3 == 3'd2) d.kind = K_LW;
                else if (opc == OPC_SW && f3 == 3'd2) begin
                    d.kind = K_SW;
                    d.imm  = {{20{s_instr[31]}}, s_instr[31:25], s_instr[11:7]};
                end else if (opc == OPC_JAL) begin
                    d.kind = K_JAL;
                    d.imm  = {{11{s_instr[31]}}, s_instr[31], s_instr[19:12],
                              s_instr[20], s_instr[30:21], 1'b0};
                end else if (opc == OPC_BR && (f3 == 3'd0 || f3 == 3'd1)) begin
                    d.kind = (f3 == 3'd0) ? K_BEQ : K_BNE;
                    d.imm  = {{19{s_instr[31]}}, s_instr[31], s_instr[7],
                              s_instr[30:25], s_instr[11:8], 1'b0};
                end
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wp_reg] <= d;
    end
endmodule

// ----- hdl/rvc_back.sv -----
module rvc_back import rvc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  dec_t        q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_halted,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_written,
    output logic [31:0] m_reg_value,
    output logic [31:0] m_read_value
);
    // Item states in order: A reads registers, B reads the memory banks, C retires
    // (a byte address memory modeled as 4 banks interleaved by address low bits).
    localparam int BANK_W = MA_W - 2;
    localparam int NBANK  = MEM_BYTES / 4;

    logic [31:0] rf [32];
    logic [7:0]  bank0 [NBANK];
    logic [7:0]  bank1 [NBANK];
    logic [7:0]  bank2 [NBANK];
    logic [7:0]  bank3 [NBANK];

    logic [31:0] pc_reg;
    logic        halt_reg;
    st_t         st_reg, st_next;
    dec_t        it_reg;
    logic [31:0] a_reg, b_reg;
    logic [4:0]  clr_reg;
    logic        clr_done_reg;
    logic [BANK_W:0] mclr_reg;
    logic        out_v_reg;
    logic [7:0]  rdb [4];

    logic [31:0] opb, ea, aluv, wval, npc;
    logic        wr;
    logic [MA_W-1:0] maddr;
    logic [MA_W-1:0] ba [4];
    logic        busy_clear;

    assign busy_clear = !clr_done_reg;
    assign opb = it_reg.use_imm ? it_reg.imm : b_reg;
    assign ea  = a_reg + it_reg.imm;
    assign maddr = (it_reg.kind == K_WRMEM || it_reg.kind == K_RDMEM) ? it_reg.addr
                                                                     : ea[MA_W-1:0];
    always_comb begin
        for (int k = 0; k < 4; k++) ba[k] = maddr + MA_W'(k);
    end

    // q_ready only in S_A, after the clearing pass, when output slot free
    assign q_ready = (st_reg == S_A) && !busy_clear && (!out_v_reg || m_ready);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_A: if (q_valid && q_ready) st_next = S_B;
            S_B: st_next = S_C;
            S_C: st_next = S_A;
            default: st_next = S_A;
        endcase
    end

    always_comb begin
        aluv = '0;
        case (it_reg.kind)
            K_ADD: aluv = a_reg + opb;
            K_SUB: aluv = a_reg - opb;
            K_XOR: aluv = a_reg ^ opb;
            K_OR:  aluv = a_reg | opb;
            K_AND: aluv = a_reg & opb;
            default: aluv = '0;
        endcase
    end

    // banks are read in S_B; the word is assembled in S_C
    logic [31:0] ldw;
    always_comb begin
        ldw = '0;
        for (int k = 0; k < 4; k++) ldw[31-8*k -: 8] = rdb[ba[k][1:0]];
    end

    always_comb begin
        wr = 1'b0; wval = '0; npc = pc_reg;
        if (!halt_reg) begin
            npc = pc_reg + 32'd4;
            case (it_reg.kind)
                K_ADD, K_SUB, K_XOR, K_OR, K_AND: begin wr = 1'b1; wval = aluv; end
                K_LW:   begin wr = 1'b1; wval = ldw; end
                K_JAL:  begin wr = 1'b1; wval = pc_reg + 32'd4; npc = pc_reg + it_reg.imm; end
                K_BEQ:  if (a_reg == b_reg) npc = pc_reg + it_reg.imm;
                K_BNE:  if (a_reg != b_reg) npc = pc_reg + it_reg.imm;
                K_HALT: npc = pc_reg;
                default: ;
            endcase
        end
        if (it_reg.rd == 5'd0) wr = 1'b0;
    end

    logic is_exec;
    assign is_exec = !(it_reg.kind == K_WRMEM || it_reg.kind == K_RDMEM ||
                       it_reg.kind == K_RDREG);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_A; pc_reg <= '0; halt_reg <= 1'b0; out_v_reg <= 1'b0;
            clr_reg <= '0; clr_done_reg <= 1'b0; mclr_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (busy_clear) begin
                clr_reg <= clr_reg + 5'd1;
                mclr_reg <= mclr_reg + (BANK_W+1)'(1);
                if (mclr_reg == (BANK_W+1)'(NBANK - 1)) clr_done_reg <= 1'b1;
            end
            if (st_reg == S_C) begin
                out_v_reg <= 1'b1;
                if (is_exec) begin
                    pc_reg <= npc;
                    if (!halt_reg && it_reg.kind == K_HALT) halt_reg <= 1'b1;
                end
            end else if (m_valid && m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // data path registers
    always_ff @(posedge aclk) begin
        if (st_reg == S_A && q_valid && q_ready) begin
            it_reg <= q_item;
            a_reg  <= rf[q_item.rs1];
            b_reg  <= rf[q_item.rs2];
        end
        if (st_reg == S_C) begin
            m_next_pc     <= is_exec ? npc : pc_reg;
            m_halted      <= is_exec ? (halt_reg || it_reg.kind == K_HALT) : halt_reg;
            m_reg_write   <= is_exec && wr;
            m_reg_written <= (is_exec && wr) ? it_reg.rd : 5'd0;
            m_reg_value   <= (is_exec && wr) ? wval : 32'd0;
            m_read_value  <= (it_reg.kind == K_RDMEM) ? ldw :
                             (it_reg.kind == K_RDREG) ? a_reg : 32'd0;
        end
    end

    // register file
    always_ff @(posedge aclk) begin
        if (busy_clear) rf[clr_reg] <= '0;
        else if (st_reg == S_C && is_exec && wr) rf[it_reg.rd] <= wval;
    end

    // data memory banks: read in S_B, write in S_C, clearing pass after reset
    logic        mwe;
    logic [31:0] mwd;
    assign mwe = (st_reg == S_C) &&
                 ((it_reg.kind == K_WRMEM) || (it_reg.kind == K_SW && !halt_reg));
    assign mwd = (it_reg.kind == K_WRMEM) ? it_reg.data : b_reg;

    logic [BANK_W-1:0] bidx [4];
    logic [7:0]        bdat [4];
    logic              bwe  [4];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            bidx[j] = '0; bdat[j] = '0; bwe[j] = 1'b0;
            for (int k = 0; k < 4; k++) begin
                if (ba[k][1:0] == 2'(j)) begin
                    bidx[j] = ba[k][MA_W-1:2];
                    bdat[j] = mwd[31-8*k -: 8];
                end
            end
            bwe[j] = mwe;
            if (busy_clear) begin
                bidx[j] = mclr_reg[BANK_W-1:0]; bdat[j] = '0; bwe[j] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (bwe[0]) bank0[bidx[0]] <= bdat[0];
        if (bwe[1]) bank1[bidx[1]] <= bdat[1];
        if (bwe[2]) bank2[bidx[2]] <= bdat[2];
        if (bwe[3]) bank3[bidx[3]] <= bdat[3];
        if (st_reg == S_B) begin
            rdb[0] <= bank0[bidx[0]];
            rdb[1] <= bank1[bidx[1]];
            rdb[2] <= bank2[bidx[2]];
            rdb[3] <= bank3[bidx[3]];
        end
    end

    assign m_valid = out_v_reg;
endmodule

// ----- hdl/rv32i_subset_single_cycle_core_top.sv -----
// Small RV32I-subset core, one item per beat. Each item passes through the execute
// unit's register read, memory bank read and retire phases, set by the synchronous
// register file and banked data memory, and the unit takes no new item until the
// last has retired; a two-entry queue and output register let input and output stall
// independently. After reset a clearing pass zeroes memory and registers before the
// first item is taken.
module rv32i_subset_single_cycle_core_top import rvc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_instr,
    input  logic [9:0]  s_mem_address,
    input  logic [31:0] s_mem_data,
    input  logic [4:0]  s_reg_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic        m_halted,
    output logic        m_reg_write,
    output logic [4:0]  m_reg_written,
    output logic [31:0] m_reg_value,
    output logic [31:0] m_read_value
);
    logic q_valid, q_ready;
    dec_t q_item;

    rvc_front u_front (.aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_instr,
        .s_mem_address, .s_mem_data, .s_reg_index, .q_valid, .q_ready, .q_item);

    rvc_back u_back (.aclk, .aresetn, .q_valid, .q_ready, .q_item, .m_valid, .m_ready,
        .m_next_pc, .m_halted, .m_reg_write, .m_reg_written, .m_reg_value, .m_read_value);
endmodule

// ----- hdl/rvc_checker.sv -----
module rvc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_next_pc,
    input logic        m_halted,
    input logic        m_reg_write,
    input logic [4:0]  m_reg_written,
    input logic [31:0] m_reg_value
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc)) else $error("m hold");
    a_x0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_write |-> m_reg_written != 5'd0) else $error("x0 write");
    a_nowr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_write |-> m_reg_value == 32'd0) else $error("stray value");
    // halt is sticky: the next beat still reports halted
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_halted ##1 m_valid[->1] |-> m_halted) else $error("halt");
endmodule

bind rv32i_subset_single_cycle_core_top rvc_checker u_chk (.aclk, .aresetn, .m_valid,
    .m_ready, .m_next_pc, .m_halted, .m_reg_write, .m_reg_written, .m_reg_value);

// ----- verif/core_checker.sv -----
`timescale 1ns / 100ps
module core_checker import rvc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_instr,
    input  logic [9:0]  s_mem_address,
    input  logic [31:0] s_mem_data,
    input  logic [4:0]  s_reg_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_next_pc,
    input  logic        m_halted,
    input  logic        m_reg_write,
    input  logic [4:0]  m_reg_written,
    input  logic [31:0] m_reg_value,
    input  logic [31:0] m_read_value,
    output int          err_count,
    output int          pending
);
    typedef struct packed {
        logic [31:0] npc;
        logic        halted;
        logic        wr;
        logic [4:0]  wreg;
        logic [31:0] wval;
        logic [31:0] rval;
    } retire_t;

    retire_t     retire_q[$];
    logic [31:0] pc;
    logic        halt_f;
    logic [31:0] regs [32];
    logic [7:0]  dmem [MEM_BYTES];

    function automatic logic [31:0] mem_rd(logic [31:0] a);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
            w = {w[23:0], dmem[(a + k) % MEM_BYTES]};
        return w;
    endfunction

    task automatic mem_wr(logic [31:0] a, logic [31:0] w);
        for (int k = 0; k < 4; k++)
            dmem[(a + k) % MEM_BYTES] = w[31 - 8 * k -: 8];
    endtask

    task automatic execute_item(logic [1:0] op, logic [31:0] ins, logic [9:0] ma,
                                logic [31:0] md, logic [4:0] ri);
        retire_t r;
        logic [6:0]  opc, f7;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [31:0] a, b, immi, imms, immj, immb;
        r = '0;
        opc = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
        a = regs[ins[19:15]]; b = regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
        immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
        case (item_op_t'(op))
            OP_WRMEM: mem_wr(ma, md);
            OP_RDMEM: r.rval = mem_rd(ma);
            OP_RDREG: r.rval = regs[ri];
            default: if (!halt_f) begin
                logic [31:0] npc;
                npc = pc + 4;
                r.wreg = rd;
                if (opc == OPC_HALT) begin
                    halt_f = 1'b1;
                    npc = pc;
                end else if (opc == OPC_R) begin
                    r.wr = 1'b1;
                    if (f7 == 0 && f3 == 0) r.wval = a + b;
                    else if (f7 == F7_SUB && f3 == 0) r.wval = a - b;
                    else if (f7 == 0 && f3 == 4) r.wval = a ^ b;
                    else if (f7 == 0 && f3 == 6) r.wval = a | b;
                    else if (f7 == 0 && f3 == 7) r.wval = a & b;
                    else r.wr = 1'b0;
                end else if (opc == OPC_I) begin
                    r.wr = 1'b1;
                    if (f3 == 0) r.wval = a + immi;
                    else if (f3 == 4) r.wval = a ^ immi;
                    else if (f3 == 6) r.wval = a | immi;
                    else if (f3 == 7) r.wval = a & immi;
                    else r.wr = 1'b0;
                end else if (opc == OPC_LW && f3 == 2) begin
                    r.wr = 1'b1;
                    r.wval = mem_rd(a + immi);
                end else if (opc == OPC_SW && f3 == 2) begin
                    mem_wr(a + imms, b);
                end else if (opc == OPC_JAL) begin
                    r.wr = 1'b1;
                    r.wval = pc + 4;
                    npc = pc + immj;
                end else if (opc == OPC_BR && (f3 == 0 || f3 == 1)) begin
                    if ((f3 == 0) == (a == b)) npc = pc + immb;
                end
                if (r.wr && rd != 0) regs[rd] = r.wval;
                else begin
                    r.wr = 1'b0; r.wreg = '0; r.wval = '0;
                end
                pc = npc;
            end
        endcase
        r.npc = pc;
        r.halted = halt_f;
        retire_q.push_back(r);
    endtask

    assign pending = retire_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            pc = '0;
            halt_f = 1'b0;
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            retire_q.delete();
            err_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (retire_q.size() == 0) begin
                    $display("%0t: unexpected result beat next_pc=%h", $time, m_next_pc);
                    err_count <= err_count + 1;
                end else begin
                    retire_t e, got;
                    e = retire_q.pop_front();
                    got = {m_next_pc, m_halted, m_reg_write, m_reg_written, m_reg_value,
                           m_read_value};
                    if (got !== e) begin
                        $display("%0t: mismatch exp pc=%h h=%b w=%b rd=%0d v=%h rv=%h",
                                 $time, e.npc, e.halted, e.wr, e.wreg, e.wval, e.rval);
                        $display("%0t:          act pc=%h h=%b w=%b rd=%0d v=%h rv=%h",
                                 $time, got.npc, got.halted, got.wr, got.wreg, got.wval,
                                 got.rval);
                        err_count <= err_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                execute_item(s_opcode, s_instr, s_mem_address, s_mem_data, s_reg_index);
        end
    end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import rvc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [31:0] s_instr = '0;
    logic [9:0]  s_mem_address = '0;
    logic [31:0] s_mem_data = '0;
    logic [4:0]  s_reg_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_pc;
    logic        m_halted, m_reg_write;
    logic [4:0]  m_reg_written;
    logic [31:0] m_reg_value, m_read_value;
    int          err_count, pending;
    int          cycle_cnt = 0;
    bit          calm = 1'b0;
    int          sink_gap = 0;

    localparam int LIMIT = 400000;

    always #5 aclk = ~aclk;

    rv32i_subset_single_cycle_core_top dut (.*);

    core_checker chk (.*);

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_ready <= aresetn;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            sink_gap <= $urandom_range(0, 6);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send(logic [1:0] op, logic [31:0] ins, logic [9:0] ma = '0,
                        logic [31:0] md = '0, logic [4:0] ri = '0);
        int gap;
        bit acc;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_instr <= ins;
        s_mem_address <= ma;
        s_mem_data <= md;
        s_reg_index <= ri;
        // ready is registered, so its mid-cycle value holds at the coming edge
        do begin
            @(negedge aclk);
            acc = s_ready;
            @(posedge aclk);
        end while (!acc);
    endtask

    function automatic logic [31:0] r_ins(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OPC_R};
    endfunction

    function automatic logic [31:0] i_ins(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] sw_ins(logic [4:0] rs1, logic [4:0] rs2, logic [11:0] imm);
        return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OPC_SW};
    endfunction

    function automatic logic [31:0] br_ins(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [12:0] off);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BR};
    endfunction

    function automatic logic [31:0] jal_ins(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    // mostly valid subset instructions, small register pool so values chain
    function automatic logic [31:0] rand_instr();
        logic [4:0] rd, a, b;
        logic [2:0] alu3 [4] = '{3'd0, 3'd4, 3'd6, 3'd7};
        rd = $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
        a = 5'($urandom_range(0, 7));
        b = 5'($urandom_range(0, 7));
        case ($urandom_range(0, 19))
            0, 1, 2: return r_ins(7'd0, alu3[$urandom_range(0, 3)], rd, a, b);
            3:       return r_ins(F7_SUB, 3'd0, rd, a, b);
            4, 5, 6: return i_ins(OPC_I, alu3[$urandom_range(0, 3)], rd, a, 12'($urandom));
            7, 8:    return i_ins(OPC_LW, 3'd2, rd, a, 12'($urandom));
            9, 10:   return sw_ins(a, b, 12'($urandom));
            11:      return jal_ins(rd, 21'($urandom));
            12, 13:  return br_ins(3'($urandom_range(0, 1)), a, b, 13'($urandom));
            14:      return $urandom_range(0, 1) ? i_ins(OPC_I, 3'($urandom), rd, a, 12'($urandom))
                                                 : r_ins(7'($urandom), 3'($urandom), rd, a, b);
            15:      return $urandom;
            default: return i_ins(OPC_I, 3'd0, rd, a, 12'($urandom));
        endcase
    endfunction

    function automatic logic [31:0] non_halt();
        logic [31:0] v;
        v = rand_instr();
        if (v[6:0] == OPC_HALT) v[0] = 1'b0;
        return v;
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        send(OP_WRMEM, '0, 10'd0, 32'hDEADBEEF);
        send(OP_WRMEM, '0, 10'd1022, 32'h11223344);
        send(OP_RDMEM, '0, 10'd1022);
        send(OP_RDMEM, '0, 10'd0);
        send(OP_EXEC, i_ins(OPC_I, 3'd0, 5'd1, 5'd0, 12'h7FF));
        send(OP_EXEC, i_ins(OPC_I, 3'd0, 5'd2, 5'd0, 12'h800));
        send(OP_EXEC, i_ins(OPC_I, 3'd4, 5'd3, 5'd1, 12'hFFF));
        send(OP_EXEC, i_ins(OPC_I, 3'd6, 5'd4, 5'd2, 12'h00F));
        send(OP_EXEC, i_ins(OPC_I, 3'd7, 5'd5, 5'd3, 12'h0F0));
        send(OP_EXEC, r_ins(7'd0, 3'd0, 5'd6, 5'd1, 5'd2));
        send(OP_EXEC, r_ins(F7_SUB, 3'd0, 5'd7, 5'd2, 5'd1));
        send(OP_EXEC, r_ins(7'd0, 3'd4, 5'd31, 5'd1, 5'd3));
        send(OP_EXEC, r_ins(7'd0, 3'd6, 5'd8, 5'd4, 5'd5));
        send(OP_EXEC, r_ins(7'd0, 3'd7, 5'd0, 5'd6, 5'd7));
        send(OP_EXEC, sw_ins(5'd0, 5'd1, 12'hFFE));
        send(OP_EXEC, i_ins(OPC_LW, 3'd2, 5'd9, 5'd0, 12'hFFE));
        send(OP_EXEC, br_ins(3'd0, 5'd0, 5'd0, 13'h1FF8));
        send(OP_EXEC, br_ins(3'd1, 5'd1, 5'd2, 13'h0FFE));
        send(OP_EXEC, jal_ins(5'd10, 21'h0FFFFE));
        send(OP_EXEC, jal_ins(5'd0, 21'h100000));
        send(OP_EXEC, 32'h0000_7033);
        send(OP_RDREG, '0, '0, '0, 5'd31);

        // random: bulk with no halts, halts confined to the tail
        for (int n = 0; n < 1550; n++) begin
            int sel;
            if (n == 1400) calm = 1'b1;
            sel = $urandom_range(0, 19);
            if (sel < 2)
                send(OP_WRMEM, $urandom, 10'($urandom), $urandom);
            else if (sel < 4)
                send(OP_RDMEM, $urandom, 10'($urandom), $urandom, 5'($urandom));
            else if (sel < 6)
                send(OP_RDREG, $urandom, 10'($urandom), $urandom, 5'($urandom));
            else if (n > 1500 && sel == 19)
                send(OP_EXEC, {25'($urandom), OPC_HALT}, 10'($urandom), $urandom);
            else
                send(OP_EXEC, non_halt(), 10'($urandom), $urandom, 5'($urandom));
        end

        // halt, then an execute that must leave everything unchanged
        send(OP_EXEC, {25'h1FFFFFF, OPC_HALT});
        send(OP_EXEC, i_ins(OPC_I, 3'd0, 5'd1, 5'd0, 12'h001));
        send(OP_RDREG, '0, '0, '0, 5'd1);
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/rvc_pkg.sv
hdl/rvc_front.sv
hdl/rvc_back.sv
hdl/rv32i_subset_single_cycle_core_top.sv
hdl/rvc_checker.sv
verif/core_checker.sv
verif/tb.sv
